[sv/pbdf_pkg.sv]
`default_nettype none
package pbdf_pkg;

   localparam int DATA_W  = 8;
   localparam int KIND_W  = 3;
   localparam int FILL_W  = 9;
   localparam int PHASE_W = 8;
   localparam int THR_W   = 7;
   localparam int INTV_W  = 8;
   localparam int CSR_W   = 8;
   localparam int CSR_IDX_W = 1;

   localparam logic [THR_W-1:0]  THR_RESET  = 7'd50;
   localparam logic [INTV_W-1:0] INTV_RESET = 8'd10;

   typedef enum logic [KIND_W-1:0] {
      KIND_PUSH_OK    = 3'd0,
      KIND_PUSH_DROP  = 3'd1,
      KIND_DRAIN_BYTE = 3'd2,
      KIND_SKIP       = 3'd3,
      KIND_TICK       = 3'd4
   } kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DRAIN_THRESHOLD = 1'b0,
      CSR_WAKE_INTERVAL   = 1'b1
   } csr_idx_type;

   typedef struct packed {
      kind_type            kind;
      logic [DATA_W-1:0]   data;
      logic                last;
      logic [FILL_W-1:0]   fill;
   } rsp_item_type;

   // room: an item may be accepted now; space_next: a slot is free after this edge
   typedef struct packed {
      logic room;
      logic space_next;
   } q_stat_type;

endpackage
`default_nettype wire

[sv/pbdf_store.sv]
`default_nettype none
module pbdf_store #(
   parameter int FIFO_DEPTH = 256,
   parameter int PTR_W      = 8
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [PTR_W-1:0]          wr_addr,
   input  wire [pbdf_pkg::DATA_W-1:0] wr_data,
   input  wire                      rd_en,
   input  wire [PTR_W-1:0]          rd_addr,
   output logic [pbdf_pkg::DATA_W-1:0] rd_data
);
   import pbdf_pkg::*;

   logic [DATA_W-1:0] mem [FIFO_DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/pbdf_out_q.sv]
`default_nettype none
module pbdf_out_q (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       push,
   input  pbdf_pkg::rsp_item_type    push_item,
   output pbdf_pkg::q_stat_type      stat,
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   output pbdf_pkg::rsp_item_type    rsp_item
);
   import pbdf_pkg::*;

   rsp_item_type slot_ff [2];
   logic         wr_idx_ff, wr_idx_in;
   logic         rd_idx_ff, rd_idx_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         pop;

   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_item   = slot_ff[rd_idx_ff];

   always_comb begin
      wr_idx_in = wr_idx_ff ^ push;
      rd_idx_in = rd_idx_ff ^ pop;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
      stat.room       = (cnt_ff != 2'd2);
      stat.space_next = (cnt_in != 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= 1'b0;
         rd_idx_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_idx_ff] <= push_item;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && cnt_ff == 2'd2 && !pop))
      else $error("output queue overflow");

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("output queue count out of range");

endmodule
`default_nettype wire

[sv/pbdf_ctrl.sv]
`default_nettype none
module pbdf_ctrl #(
   parameter int FIFO_DEPTH = 256,
   parameter int MAX_DRAIN  = 64,
   parameter int PTR_W      = 8,
   parameter int OCC_W      = 9,
   parameter int REM_W      = 7
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_tvalid,
   output logic                        req_tready,
   input  wire                         func,
   input  wire [pbdf_pkg::DATA_W-1:0]  data_in,
   input  wire [pbdf_pkg::THR_W-1:0]   thr_cfg,
   input  wire [pbdf_pkg::INTV_W-1:0]  intv_cfg,
   input  pbdf_pkg::q_stat_type        q_stat,
   output logic                        push,
   output pbdf_pkg::rsp_item_type      push_item,
   output logic                        mem_we,
   output logic [PTR_W-1:0]            mem_waddr,
   output logic [pbdf_pkg::DATA_W-1:0] mem_wdata,
   output logic                        mem_re,
   output logic [PTR_W-1:0]            mem_raddr,
   input  wire [pbdf_pkg::DATA_W-1:0]  mem_rdata
);
   import pbdf_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [OCC_W-1:0]     occ_ff, occ_in;
   logic [PHASE_W-1:0]   phase_ff, phase_in;
   logic [REM_W-1:0]     rem_ff, rem_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic                 pend_last_ff, pend_last_in;
   logic [FILL_W-1:0]    pend_fill_ff, pend_fill_in;

   logic                 accept;
   logic [REM_W-1:0]     thr_eff;
   logic [INTV_W-1:0]    intv_eff;
   logic [PHASE_W-1:0]   phase_nxt;
   logic                 full;
   logic [OCC_W-1:0]     occ_dec;

   assign req_tready = (state_ff == ST_IDLE) && !pend_valid_ff && q_stat.room;
   assign accept     = req_tvalid && req_tready;
   assign full       = (occ_ff == OCC_W'(FIFO_DEPTH));
   assign phase_nxt  = phase_ff + PHASE_W'(1);
   assign intv_eff   = (intv_cfg == '0) ? INTV_W'(1) : intv_cfg;
   assign occ_dec    = occ_ff - OCC_W'(1);

   always_comb begin
      if (32'(thr_cfg) > MAX_DRAIN) begin
         thr_eff = REM_W'(MAX_DRAIN);
      end else if (thr_cfg == '0) begin
         thr_eff = REM_W'(1);
      end else begin
         thr_eff = REM_W'(thr_cfg);
      end
   end

   always_comb begin
      state_in      = state_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      occ_in        = occ_ff;
      phase_in      = phase_ff;
      rem_in        = rem_ff;
      pend_valid_in = 1'b0;
      pend_last_in  = pend_last_ff;
      pend_fill_in  = pend_fill_ff;

      mem_we    = 1'b0;
      mem_waddr = wr_ptr_ff;
      mem_wdata = data_in;
      mem_re    = 1'b0;
      mem_raddr = rd_ptr_ff;

      push           = 1'b0;
      push_item.kind = KIND_DRAIN_BYTE;
      push_item.data = mem_rdata;
      push_item.last = pend_last_ff;
      push_item.fill = pend_fill_ff;

      // drained byte lands from the store in the cycle after its read
      if (pend_valid_ff) begin
         push = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               push_item.data = '0;
               push_item.last = 1'b1;
               push_item.fill = FILL_W'(occ_ff);
               if (!func) begin
                  push = 1'b1;
                  if (full) begin
                     push_item.kind = KIND_PUSH_DROP;
                  end else begin
                     push_item.kind = KIND_PUSH_OK;
                     push_item.fill = FILL_W'(occ_ff + OCC_W'(1));
                     mem_we = 1'b1;
                     occ_in = occ_ff + OCC_W'(1);
                     wr_ptr_in = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                       : wr_ptr_ff + PTR_W'(1);
                  end
               end else if ((phase_nxt < intv_eff) && (phase_nxt != '0)) begin
                  push           = 1'b1;
                  push_item.kind = KIND_TICK;
                  phase_in       = phase_nxt;
               end else begin
                  phase_in = '0;
                  if (32'(occ_ff) < 32'(thr_eff)) begin
                     push           = 1'b1;
                     push_item.kind = KIND_SKIP;
                  end else begin
                     state_in = ST_DRAIN;
                     rem_in   = thr_eff;
                  end
               end
            end
         end
         ST_DRAIN: begin
            // issue a read only when its byte is sure of a queue slot
            if (q_stat.space_next) begin
               mem_re        = 1'b1;
               rd_ptr_in     = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                                     : rd_ptr_ff + PTR_W'(1);
               occ_in        = occ_dec;
               rem_in        = rem_ff - REM_W'(1);
               pend_valid_in = 1'b1;
               pend_last_in  = (rem_ff == REM_W'(1));
               pend_fill_in  = FILL_W'(occ_dec);
               if (rem_ff == REM_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         occ_ff        <= '0;
         phase_ff      <= '0;
         rem_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wr_ptr_ff     <= wr_ptr_in;
         rd_ptr_ff     <= rd_ptr_in;
         occ_ff        <= occ_in;
         phase_ff      <= phase_in;
         rem_ff        <= rem_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_last_ff <= pend_last_in;
      pend_fill_ff <= pend_fill_in;
   end

   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) <= FIFO_DEPTH)
      else $error("occupancy beyond depth");

   a_drain_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (rem_ff != '0) && (32'(occ_ff) >= 32'(rem_ff)))
      else $error("drain count inconsistent with occupancy");

   a_no_rw_clash: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("store written and read in one cycle");

   a_last_ends_drain: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && pend_last_ff) |-> (state_ff == ST_IDLE))
      else $error("last drained byte while still draining");

endmodule
`default_nettype wire

[sv/periodic_batch_drain_fifo_core.sv]
`default_nettype none
// Circular byte FIFO with periodic batch drain. req items carry a push (tuser 0,
// byte in tdata) or a time tick (tuser 1). A push or a tick that does not drain
// gives one result item; a draining tick of N bytes holds req_tready low until
// its last byte is queued, one byte per cycle while the result queue has room.
// A two-entry result queue lets new items enter while earlier results wait.
// Results carry the kind in tuser, the drained byte and the fill level in tdata,
// and tlast on the final result of each item. The user must write threshold and
// interval through the csr port only while the block is idle; the block does not
// enforce this. A zero value acts as one; a threshold above MAX_DRAIN is clamped.
module periodic_batch_drain_fifo_core #(
   parameter int FIFO_DEPTH = 256,
   parameter int MAX_DRAIN  = 64
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire [7:0]   req_tdata,   // [7:0] data_in
   input  wire [0:0]   req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] data_out, [16:8] fill_level, rest zero
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast,
   input  wire         csr_we,
   input  wire [pbdf_pkg::CSR_IDX_W-1:0] csr_idx,
   input  wire [pbdf_pkg::CSR_W-1:0]     csr_wdata
);
   import pbdf_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int OCC_W = $clog2(FIFO_DEPTH + 1);
   localparam int REM_W = $clog2(MAX_DRAIN + 1);

   logic [THR_W-1:0]  thr_ff;
   logic [INTV_W-1:0] intv_ff;

   q_stat_type        q_stat;
   logic              push;
   rsp_item_type      push_item;
   rsp_item_type      rsp_item;
   logic              mem_we, mem_re;
   logic [PTR_W-1:0]  mem_waddr, mem_raddr;
   logic [DATA_W-1:0] mem_wdata, mem_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= THR_RESET;
         intv_ff <= INTV_RESET;
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_idx))
            CSR_DRAIN_THRESHOLD: thr_ff  <= csr_wdata[THR_W-1:0];
            CSR_WAKE_INTERVAL:   intv_ff <= csr_wdata[INTV_W-1:0];
            default: ;
         endcase
      end
   end

   pbdf_ctrl #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .MAX_DRAIN  (MAX_DRAIN),
      .PTR_W      (PTR_W),
      .OCC_W      (OCC_W),
      .REM_W      (REM_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .func       (req_tuser[0]),
      .data_in    (req_tdata),
      .thr_cfg    (thr_ff),
      .intv_cfg   (intv_ff),
      .q_stat     (q_stat),
      .push       (push),
      .push_item  (push_item),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   pbdf_store #(
      .FIFO_DEPTH (FIFO_DEPTH),
      .PTR_W      (PTR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   pbdf_out_q u_out_q (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .stat       (q_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_item   (rsp_item)
   );

   assign rsp_tdata = {7'd0, rsp_item.fill, rsp_item.data};
   assign rsp_tuser = rsp_item.kind;
   assign rsp_tlast = rsp_item.last;

endmodule
`default_nettype wire

[tb/periodic_batch_drain_fifo_core_test.sv]
`timescale 1ns / 1ps

module periodic_batch_drain_fifo_core_test;
   import pbdf_pkg::*;

   localparam int STORE_DEPTH    = 256;
   localparam int DRAIN_MAX      = 64;
   localparam int CSR_SETTLE     = 4;
   localparam int END_SETTLE     = 20;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int RANDOM_PHASES  = 4;
   localparam int PHASE_ITEMS    = 12;

   typedef enum logic [1:0] {
      STEP_PUSH,
      STEP_TICK,
      STEP_CSR
   } step_op_type;

   typedef struct {
      step_op_type  op;
      csr_idx_type  idx;
      logic [7:0]   value;
      int           count;
      bit           typed;
      rsp_item_type want;
   } step_row_type;

   logic                 clock;
   logic                 reset = 1'b1;
   logic                 req_tvalid;
   logic                 req_tready;
   logic [7:0]           req_tdata;   // [7:0] data_in
   logic [0:0]           req_tuser;   // [0] func
   logic                 rsp_tvalid;
   logic                 rsp_tready;
   logic [23:0]          rsp_tdata;   // [7:0] data_out, [16:8] fill_level, rest zero
   logic [2:0]           rsp_tuser;   // [2:0] kind
   logic                 rsp_tlast;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_idx;
   logic [CSR_W-1:0]     csr_wdata;

   // mirror of the block's state
   logic [7:0]        mirror_store [STORE_DEPTH];
   logic [7:0]        mirror_wr;
   logic [7:0]        mirror_rd;
   logic [8:0]        mirror_fill;
   logic [7:0]        mirror_phase;
   logic [THR_W-1:0]  mirror_thr;
   logic [INTV_W-1:0] mirror_intv;

   rsp_item_type pending_results [$];
   step_row_type directed_rows [$];
   int           fail_count = 0;
   int           quiet_cycles = 0;
   int           req_idle_pct = 25;
   int           rsp_idle_pct = 25;
   bit           no_idle = 1'b0;

   periodic_batch_drain_fifo_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_idx    (csr_idx),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
      fail_count++;
   endtask

   task automatic check_field(input string what, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   // works out the results of one accepted item and queues them
   task automatic forecast_fifo(input bit is_tick, input logic [7:0] din);
      rsp_item_type r;
      int intv_eff;
      int thr_eff;
      logic [7:0] phase_nx;
      r = '0;
      r.last = 1'b1;
      if (!is_tick) begin
         if (mirror_fill >= 9'(STORE_DEPTH)) begin
            r.kind = KIND_PUSH_DROP;
         end else begin
            mirror_store[mirror_wr] = din;
            mirror_wr++;
            mirror_fill++;
            r.kind = KIND_PUSH_OK;
         end
         r.fill = mirror_fill;
         pending_results.push_back(r);
      end else begin
         intv_eff = (mirror_intv == 0) ? 1 : mirror_intv;
         phase_nx = mirror_phase + 8'd1;
         if (phase_nx < intv_eff && phase_nx != 0) begin
            mirror_phase = phase_nx;
            r.kind = KIND_TICK;
            r.fill = mirror_fill;
            pending_results.push_back(r);
         end else begin
            mirror_phase = '0;
            thr_eff = (mirror_thr == 0) ? 1 : mirror_thr;
            if (thr_eff > DRAIN_MAX)
               thr_eff = DRAIN_MAX;
            if (mirror_fill < thr_eff) begin
               r.kind = KIND_SKIP;
               r.fill = mirror_fill;
               pending_results.push_back(r);
            end else begin
               for (int i = 0; i < thr_eff; i++) begin
                  r.kind = KIND_DRAIN_BYTE;
                  r.data = mirror_store[mirror_rd];
                  mirror_rd++;
                  mirror_fill--;
                  r.last = (i == thr_eff - 1);
                  r.fill = mirror_fill;
                  pending_results.push_back(r);
               end
            end
         end
      end
   endtask

   task automatic send_item(input bit is_tick, input logic [7:0] din);
      if (!no_idle && $urandom_range(99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= is_tick;
      req_tdata  <= din;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      forecast_fifo(is_tick, din);
   endtask

   // only while idle: waits for all results to come in and lets the block settle
   task automatic write_csr(input csr_idx_type idx, input logic [7:0] value);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (CSR_SETTLE) @(posedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_DRAIN_THRESHOLD)
         mirror_thr = value[THR_W-1:0];
      else
         mirror_intv = value;
   endtask

   task automatic add_row(input step_op_type op, input csr_idx_type idx,
                          input logic [7:0] value, input int count, input bit typed,
                          input kind_type kind, input logic [7:0] data,
                          input logic [8:0] fill);
      step_row_type row;
      row.op         = op;
      row.idx        = idx;
      row.value      = value;
      row.count      = count;
      row.typed      = typed;
      row.want.kind  = kind;
      row.want.data  = data;
      row.want.last  = 1'b1;
      row.want.fill  = fill;
      directed_rows.push_back(row);
   endtask

   // result side: random stall bursts, none in the final phase
   initial begin
      forever begin
         if (no_idle || $urandom_range(99) >= rsp_idle_pct) begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result with nothing expected", rsp_tdata, 0);
         end else begin
            want = pending_results.pop_front();
            check_field("kind", rsp_tuser, want.kind);
            check_field("data_out", rsp_tdata[7:0], want.data);
            check_field("fill_level", rsp_tdata[16:8], want.fill);
            check_field("tdata pad", rsp_tdata[23:17], 0);
            check_field("last", rsp_tlast, want.last);
         end
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("periodic_batch_drain_fifo_core regression: fail");
      $finish;
   end

   initial begin : stimulus
      step_row_type row;
      logic [7:0] din;
      int push_pct;

      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_we     <= 1'b0;
      csr_idx    <= CSR_DRAIN_THRESHOLD;
      csr_wdata  <= '0;
      mirror_wr    = '0;
      mirror_rd    = '0;
      mirror_fill  = '0;
      mirror_phase = '0;
      mirror_thr   = THR_RESET;
      mirror_intv  = INTV_RESET;

      // reset values: threshold 50, interval 10
      add_row(STEP_TICK, CSR_DRAIN_THRESHOLD, 8'h00, 1, 1, KIND_TICK, 8'h00, 9'd0);
      add_row(STEP_PUSH, CSR_DRAIN_THRESHOLD, 8'h00, 1, 1, KIND_PUSH_OK, 8'h00, 9'd1);
      add_row(STEP_PUSH, CSR_DRAIN_THRESHOLD, 8'hFF, 1, 1, KIND_PUSH_OK, 8'h00, 9'd2);
      add_row(STEP_TICK, CSR_DRAIN_THRESHOLD, 8'h00, 8, 0, KIND_TICK, 8'h00, 9'd0);
      add_row(STEP_TICK, CSR_DRAIN_THRESHOLD, 8'h00, 1, 1, KIND_SKIP, 8'h00, 9'd2);
      // zero threshold and zero interval both act as one
      add_row(STEP_CSR, CSR_DRAIN_THRESHOLD, 8'h00, 1, 0, KIND_TICK, 8'h00, 9'd0);
      add_row(STEP_CSR, CSR_WAKE_INTERVAL, 8'h00, 1, 0, KIND_TICK, 8'h00, 9'd0);
      add_row(STEP_TICK, CSR_DRAIN_THRESHOLD, 8'h00, 1, 1, KIND_DRAIN_BYTE, 8'h00, 9'd1);
      add_row(STEP_TICK, CSR_DRAIN_THRESHOLD, 8'h00, 1, 1, KIND_DRAIN_BYTE, 8'hFF, 9'd0);
      add_row(STEP_TICK, CSR_DRAIN_THRESHOLD, 8'h00, 1, 1, KIND_SKIP, 8'h00, 9'd0);
      // top bit dropped, 127 clamps to the largest batch
      add_row(STEP_CSR, CSR_DRAIN_THRESHOLD, 8'hFF, 1, 0, KIND_TICK, 8'h00, 9'd0);
      add_row(STEP_CSR, CSR_WAKE_INTERVAL, 8'hFF, 1, 0, KIND_TICK, 8'h00, 9'd0);
      add_row(STEP_PUSH, CSR_DRAIN_THRESHOLD, 8'h00, STORE_DEPTH, 0, KIND_PUSH_OK,
              8'h00, 9'd0);
      add_row(STEP_PUSH, CSR_DRAIN_THRESHOLD, 8'hA5, 1, 1, KIND_PUSH_DROP, 8'h00, 9'd256);
      add_row(STEP_TICK, CSR_DRAIN_THRESHOLD, 8'h00, 3, 0, KIND_TICK, 8'h00, 9'd0);
      // interval lowered below the running count: next tick checks at once
      add_row(STEP_CSR, CSR_WAKE_INTERVAL, 8'h02, 1, 0, KIND_TICK, 8'h00, 9'd0);
      add_row(STEP_TICK, CSR_DRAIN_THRESHOLD, 8'h00, 1, 0, KIND_TICK, 8'h00, 9'd0);
      add_row(STEP_CSR, CSR_DRAIN_THRESHOLD, 8'h40, 1, 0, KIND_TICK, 8'h00, 9'd0);
      add_row(STEP_CSR, CSR_WAKE_INTERVAL, 8'h01, 1, 0, KIND_TICK, 8'h00, 9'd0);
      add_row(STEP_TICK, CSR_DRAIN_THRESHOLD, 8'h00, 3, 0, KIND_TICK, 8'h00, 9'd0);
      add_row(STEP_TICK, CSR_DRAIN_THRESHOLD, 8'h00, 1, 1, KIND_SKIP, 8'h00, 9'd0);
      add_row(STEP_CSR, CSR_DRAIN_THRESHOLD, 8'h80, 1, 0, KIND_TICK, 8'h00, 9'd0);
      add_row(STEP_PUSH, CSR_DRAIN_THRESHOLD, 8'h00, 4, 0, KIND_PUSH_OK, 8'h00, 9'd0);
      add_row(STEP_TICK, CSR_DRAIN_THRESHOLD, 8'h00, 4, 0, KIND_TICK, 8'h00, 9'd0);
      add_row(STEP_TICK, CSR_DRAIN_THRESHOLD, 8'h00, 1, 1, KIND_SKIP, 8'h00, 9'd0);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < directed_rows.size(); r++) begin
         row = directed_rows[r];
         if (row.op == STEP_CSR) begin
            write_csr(row.idx, row.value);
         end else begin
            repeat (row.count) begin
               din = (row.op == STEP_TICK || row.count > 1) ? 8'($urandom) : row.value;
               send_item(row.op == STEP_TICK, din);
               // hand-written expectation takes the mirror's place
               if (row.typed) begin
                  void'(pending_results.pop_back());
                  pending_results.push_back(row.want);
               end
            end
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         no_idle = (p == RANDOM_PHASES - 1);
         req_idle_pct = no_idle ? 0 : $urandom_range(0, 40);
         rsp_idle_pct = no_idle ? 0 : $urandom_range(0, 40);
         write_csr(CSR_DRAIN_THRESHOLD, ($urandom_range(4) == 0) ? 8'($urandom)
                                                               : 8'($urandom_range(1, 12)));
         write_csr(CSR_WAKE_INTERVAL, ($urandom_range(4) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(1, 6)));
         push_pct = $urandom_range(35, 85);
         repeat (PHASE_ITEMS)
            send_item($urandom_range(99) >= push_pct, 8'($urandom));
      end

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (END_SETTLE) @(posedge clock);
      if (fail_count == 0)
         $display("periodic_batch_drain_fifo_core regression: pass");
      else
         $display("periodic_batch_drain_fifo_core regression: fail");
      $finish;
   end

endmodule

[sim.f]
sv/pbdf_pkg.sv
sv/pbdf_store.sv
sv/pbdf_out_q.sv
sv/pbdf_ctrl.sv
sv/periodic_batch_drain_fifo_core.sv
tb/periodic_batch_drain_fifo_core_test.sv
